// ===== rtl/ctspl_pkg.sv =====
`default_nettype none

package ctspl_pkg;

	localparam int CAPACITY    = 16;
	localparam int CLASS_COUNT = 5;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	localparam logic [2:0] CMD_CLEAR   = 3'd0;
	localparam logic [2:0] CMD_INSERT  = 3'd1;
	localparam logic [2:0] CMD_POP     = 3'd2;
	localparam logic [2:0] CMD_POP_CLS = 3'd3;
	localparam logic [2:0] CMD_POP_NOT = 3'd4;
	localparam logic [2:0] CMD_REMOVE  = 3'd5;
	localparam logic [2:0] CMD_QUERY   = 3'd6;
	localparam logic [2:0] CMD_LOOKUP  = 3'd7;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic signed [31:0] weight;
		logic [7:0]         item;
		logic [2:0]         cls;
	} entry_t;

	typedef struct packed {
		logic signed [31:0] weight;
		logic [7:0]         item;
		logic [2:0]         cls;
		logic [4:0]         mask;
	} key_t;

endpackage

`default_nettype wire

// ===== rtl/ctspl_ram.sv =====
`default_nettype none

module ctspl_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ctspl_match.sv =====
`default_nettype none

module ctspl_match
	import ctspl_pkg::*;
(
	input  wire logic [2:0] cmd,
	input  wire key_t       key,
	input  wire entry_t     entry,
	output logic            hit
);

	logic [7:0] mask_ext;

	assign mask_ext = {3'b000, key.mask};

	always_comb begin
		case (cmd)
			CMD_INSERT:  hit = $signed(key.weight) >= $signed(entry.weight);
			CMD_POP:     hit = 1'b1;
			CMD_POP_CLS: hit = entry.cls == key.cls;
			CMD_POP_NOT: hit = entry.cls != key.cls;
			CMD_QUERY:   hit = (entry.cls < 3'(CLASS_COUNT)) && mask_ext[entry.cls];
			CMD_REMOVE,
			CMD_LOOKUP:  hit = (entry.item == key.item) && (entry.cls == key.cls);
			default:     hit = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/class_tagged_sorted_priority_list.sv =====
`default_nettype none

// Sorted priority list of up to 16 entries (item, class, signed weight),
// highest weight first, newest first among equal weights.
// A command is taken at a clock edge with start high and busy low; busy
// stays high until the command is finished. Every command gives exactly
// one result beat: done is high for one cycle with status, out_item,
// out_class, out_weight and entry_count. The receiver has no way to stall.
// Clear, a rejected insert and any command but insert on an empty list
// raise done at the accepting edge itself, with busy never raised. Other
// commands scan the entry memory through one compare unit, one entry per
// cycle behind the registered read, and stop at the matching entry; insert,
// pop and remove then shift any entries behind it one entry per cycle
// through the single write port. done rises at the edge at which busy
// falls, and a new command may be given in that same cycle.
// Reset empties the list; entry contents are not cleared and need no pass.
module class_tagged_sorted_priority_list
	import ctspl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         command,
	input  wire logic [7:0]         item_id,
	input  wire logic [2:0]         item_class,
	input  wire logic signed [31:0] weight,
	input  wire logic [4:0]         class_mask,
	output logic                    done,
	output logic [1:0]              status,
	output logic [7:0]              out_item,
	output logic [2:0]              out_class,
	output logic signed [31:0]      out_weight,
	output logic [CNT_W-1:0]        entry_count
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHDN,
		S_SHUP,
		S_WRNEW
	} state_t;

	state_t             state_q;
	logic [2:0]         cmd_q;
	key_t               key_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   scan_q;
	logic [CNT_W-1:0]   pos_q;
	logic               chk_vld_s1;
	logic [IDX_W-1:0]   chk_idx_s1;
	logic               done_q;
	logic [1:0]         status_q;
	logic [7:0]         item_q;
	logic [2:0]         class_q;
	logic signed [31:0] weight_q;
	logic [CNT_W-1:0]   ecount_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_wa;
	entry_t             ram_wd;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_ra;
	entry_t             ram_rd;
	logic               hit;
	logic [CNT_W-1:0]   idx_ext;
	logic [CNT_W-1:0]   scan_nxt;
	logic [CNT_W-1:0]   scan_prv;
	entry_t             new_entry;

	assign idx_ext   = {{(CNT_W-IDX_W){1'b0}}, chk_idx_s1};
	assign scan_nxt  = scan_q + CNT_W'(1);
	assign scan_prv  = scan_q - CNT_W'(1);
	assign new_entry = '{weight: key_q.weight, item: key_q.item, cls: key_q.cls};

	ctspl_ram #(
		.DATA_W($bits(entry_t)),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_wa),
		.wdata(ram_wd),
		.re   (ram_re),
		.raddr(ram_ra),
		.rdata(ram_rd)
	);

	ctspl_match u_match (
		.cmd  (cmd_q),
		.key  (key_q),
		.entry(ram_rd),
		.hit  (hit)
	);

	always_comb begin
		ram_we = 1'b0;
		ram_wa = chk_idx_s1;
		ram_wd = ram_rd;
		ram_re = 1'b0;
		ram_ra = scan_q[IDX_W-1:0];
		case (state_q)
			S_SCAN: begin
				ram_re = scan_q < count_q;
			end
			S_SHDN: begin
				ram_re = scan_nxt < count_q;
				ram_ra = scan_nxt[IDX_W-1:0];
				ram_we = chk_vld_s1;
			end
			S_SHUP: begin
				ram_re = scan_q > pos_q;
				ram_ra = scan_prv[IDX_W-1:0];
				ram_we = chk_vld_s1;
			end
			S_WRNEW: begin
				ram_we = 1'b1;
				ram_wa = pos_q[IDX_W-1:0];
				ram_wd = new_entry;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= CMD_CLEAR;
			key_q      <= '0;
			count_q    <= '0;
			scan_q     <= '0;
			pos_q      <= '0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
			done_q     <= 1'b0;
			status_q   <= ST_OK;
			item_q     <= '0;
			class_q    <= '0;
			weight_q   <= '0;
			ecount_q   <= '0;
		end else begin
			done_q     <= 1'b0;
			chk_vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q    <= command;
						key_q    <= '{weight: weight, item: item_id, cls: item_class,
							mask: class_mask};
						scan_q   <= '0;
						status_q <= ST_OK;
						item_q   <= '0;
						class_q  <= '0;
						weight_q <= '0;
						ecount_q <= count_q;
						case (command)
							CMD_CLEAR: begin
								count_q  <= '0;
								ecount_q <= '0;
								done_q   <= 1'b1;
							end
							CMD_INSERT: begin
								if (count_q >= CNT_W'(CAPACITY)) begin
									status_q <= ST_FULL;
									done_q   <= 1'b1;
								end else if (item_class >= 3'(CLASS_COUNT)) begin
									status_q <= ST_NONE;
									done_q   <= 1'b1;
								end else if (count_q == '0) begin
									pos_q   <= '0;
									state_q <= S_WRNEW;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								if (count_q == '0) begin
									status_q <= ST_NONE;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (ram_re) begin
						scan_q <= scan_nxt;
					end
					chk_vld_s1 <= ram_re;
					chk_idx_s1 <= scan_q[IDX_W-1:0];
					if (chk_vld_s1 && (hit || (idx_ext + CNT_W'(1) == count_q))) begin
						chk_vld_s1 <= 1'b0;
						case (cmd_q)
							CMD_INSERT: begin
								if (!hit) begin
									pos_q   <= count_q;
									state_q <= S_WRNEW;
								end else begin
									pos_q   <= idx_ext;
									scan_q  <= count_q;
									state_q <= S_SHUP;
								end
							end
							CMD_POP, CMD_POP_CLS, CMD_POP_NOT, CMD_REMOVE: begin
								if (!hit) begin
									status_q <= ST_NONE;
									ecount_q <= count_q;
									done_q   <= 1'b1;
									state_q  <= S_IDLE;
								end else begin
									item_q   <= ram_rd.item;
									class_q  <= ram_rd.cls;
									weight_q <= ram_rd.weight;
									if (idx_ext + CNT_W'(1) == count_q) begin
										count_q  <= count_q - CNT_W'(1);
										ecount_q <= count_q - CNT_W'(1);
										done_q   <= 1'b1;
										state_q  <= S_IDLE;
									end else begin
										scan_q  <= idx_ext;
										state_q <= S_SHDN;
									end
								end
							end
							default: begin
								if (hit) begin
									item_q   <= ram_rd.item;
									class_q  <= ram_rd.cls;
									weight_q <= ram_rd.weight;
								end else begin
									status_q <= ST_NONE;
								end
								ecount_q <= count_q;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end
						endcase
					end
				end
				S_SHDN: begin
					if (ram_re) begin
						scan_q <= scan_nxt;
					end
					chk_vld_s1 <= ram_re;
					chk_idx_s1 <= scan_q[IDX_W-1:0];
					if (chk_vld_s1 && (idx_ext + CNT_W'(2) == count_q)) begin
						chk_vld_s1 <= 1'b0;
						count_q    <= count_q - CNT_W'(1);
						ecount_q   <= count_q - CNT_W'(1);
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_SHUP: begin
					if (ram_re) begin
						scan_q <= scan_prv;
					end
					chk_vld_s1 <= ram_re;
					chk_idx_s1 <= scan_q[IDX_W-1:0];
					if (chk_vld_s1 && (idx_ext == pos_q + CNT_W'(1))) begin
						chk_vld_s1 <= 1'b0;
						state_q    <= S_WRNEW;
					end
				end
				S_WRNEW: begin
					count_q  <= count_q + CNT_W'(1);
					ecount_q <= count_q + CNT_W'(1);
					status_q <= ST_OK;
					item_q   <= key_q.item;
					class_q  <= key_q.cls;
					weight_q <= key_q.weight;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign out_item    = item_q;
	assign out_class   = class_q;
	assign out_weight  = weight_q;
	assign entry_count = ecount_q;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import ctspl_pkg::*;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         item;
		logic [2:0]         cls;
		logic signed [31:0] weight;
		logic [CNT_W-1:0]   count;
	} result_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [7:0]         item;
		logic [2:0]         cls;
		logic signed [31:0] weight;
		logic [4:0]         mask;
		logic               has_exp;
		result_t            exp;
	} stim_t;

	localparam result_t NO_EXP = '0;
	localparam logic signed [31:0] W_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] W_MIN = 32'sh8000_0000;

	localparam stim_t DIRECTED [0:23] = '{
		'{CMD_POP,     8'h00, 3'd0, 32'sd0, 5'h00, 1'b1, '{ST_NONE, 8'h00, 3'd0, 32'sd0, 5'd0}},
		'{CMD_QUERY,   8'h00, 3'd0, 32'sd0, 5'h1f, 1'b1, '{ST_NONE, 8'h00, 3'd0, 32'sd0, 5'd0}},
		'{CMD_LOOKUP,  8'h00, 3'd0, 32'sd0, 5'h00, 1'b1, '{ST_NONE, 8'h00, 3'd0, 32'sd0, 5'd0}},
		'{CMD_INSERT,  8'hff, 3'd4, W_MAX,  5'h00, 1'b1, '{ST_OK,   8'hff, 3'd4, W_MAX,  5'd1}},
		'{CMD_INSERT,  8'h00, 3'd0, W_MIN,  5'h00, 1'b1, '{ST_OK,   8'h00, 3'd0, W_MIN,  5'd2}},
		'{CMD_INSERT,  8'h55, 3'd7, 32'sd0, 5'h00, 1'b1, '{ST_NONE, 8'h00, 3'd0, 32'sd0, 5'd2}},
		'{CMD_INSERT,  8'haa, 3'd2, 32'sd0, 5'h00, 1'b0, NO_EXP},
		'{CMD_INSERT,  8'haa, 3'd2, 32'sd0, 5'h00, 1'b0, NO_EXP},
		'{CMD_INSERT,  8'h3c, 3'd3, -32'sd1, 5'h00, 1'b0, NO_EXP},
		'{CMD_INSERT,  8'hc3, 3'd1, 32'sd0, 5'h00, 1'b0, NO_EXP},
		'{CMD_QUERY,   8'h00, 3'd0, 32'sd0, 5'h04, 1'b0, NO_EXP},
		'{CMD_QUERY,   8'h00, 3'd0, 32'sd0, 5'h00, 1'b1, '{ST_NONE, 8'h00, 3'd0, 32'sd0, 5'd6}},
		'{CMD_POP_CLS, 8'h00, 3'd6, 32'sd0, 5'h00, 1'b1, '{ST_NONE, 8'h00, 3'd0, 32'sd0, 5'd6}},
		'{CMD_POP_NOT, 8'h00, 3'd7, 32'sd0, 5'h00, 1'b0, NO_EXP},
		'{CMD_POP_NOT, 8'h00, 3'd1, 32'sd0, 5'h00, 1'b0, NO_EXP},
		'{CMD_POP_CLS, 8'h00, 3'd0, 32'sd0, 5'h00, 1'b0, NO_EXP},
		'{CMD_LOOKUP,  8'haa, 3'd2, 32'sd0, 5'h00, 1'b0, NO_EXP},
		'{CMD_LOOKUP,  8'haa, 3'd3, 32'sd0, 5'h00, 1'b0, NO_EXP},
		'{CMD_REMOVE,  8'haa, 3'd2, 32'sd0, 5'h00, 1'b0, NO_EXP},
		'{CMD_REMOVE,  8'h77, 3'd1, 32'sd0, 5'h00, 1'b0, NO_EXP},
		'{CMD_LOOKUP,  8'h3c, 3'd3, W_MAX,  5'h1f, 1'b0, NO_EXP},
		'{CMD_POP,     8'hff, 3'd7, W_MIN,  5'h1f, 1'b0, NO_EXP},
		'{CMD_CLEAR,   8'h00, 3'd0, 32'sd0, 5'h00, 1'b1, '{ST_OK,   8'h00, 3'd0, 32'sd0, 5'd0}},
		'{CMD_POP_CLS, 8'h00, 3'd0, 32'sd0, 5'h00, 1'b1, '{ST_NONE, 8'h00, 3'd0, 32'sd0, 5'd0}}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [2:0]         command = '0;
	logic [7:0]         item_id = '0;
	logic [2:0]         item_class = '0;
	logic signed [31:0] weight = '0;
	logic [4:0]         class_mask = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [7:0]         out_item;
	logic [2:0]         out_class;
	logic signed [31:0] out_weight;
	logic [CNT_W-1:0]   entry_count;

	entry_t  held_list[$];
	result_t pending_results[$];
	int      mismatches = 0;
	int      idle_pct = 6;

	class_tagged_sorted_priority_list u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.item_id    (item_id),
		.item_class (item_class),
		.weight     (weight),
		.class_mask (class_mask),
		.done       (done),
		.status     (status),
		.out_item   (out_item),
		.out_class  (out_class),
		.out_weight (out_weight),
		.entry_count(entry_count)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// applies one command to the list copy and returns the result it gives
	function automatic result_t list_apply(input stim_t s);
		result_t r;
		entry_t  e;
		int      pos;
		bit      hit;
		r = '0;
		r.status = ST_OK;
		pos = -1;
		case (s.cmd)
			CMD_CLEAR: held_list.delete();
			CMD_INSERT: begin
				if (held_list.size() >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (s.cls >= CLASS_COUNT) begin
					r.status = ST_NONE;
				end else begin
					pos = 0;
					while (pos < held_list.size() && $signed(s.weight) < $signed(held_list[pos].weight))
						pos++;
					e.weight = s.weight;
					e.item = s.item;
					e.cls = s.cls;
					held_list.insert(pos, e);
					r.item = e.item;
					r.cls = e.cls;
					r.weight = e.weight;
				end
			end
			default: begin
				for (int i = 0; i < held_list.size() && pos < 0; i++) begin
					e = held_list[i];
					case (s.cmd)
						CMD_POP:     hit = 1'b1;
						CMD_POP_CLS: hit = (e.cls == s.cls);
						CMD_POP_NOT: hit = (e.cls != s.cls);
						CMD_QUERY:   hit = (e.cls < CLASS_COUNT) && s.mask[e.cls];
						default:     hit = (e.item == s.item) && (e.cls == s.cls);
					endcase
					if (hit)
						pos = i;
				end
				if (pos < 0) begin
					r.status = ST_NONE;
				end else begin
					r.item = held_list[pos].item;
					r.cls = held_list[pos].cls;
					r.weight = held_list[pos].weight;
					if (s.cmd != CMD_QUERY && s.cmd != CMD_LOOKUP)
						held_list.delete(pos);
				end
			end
		endcase
		r.count = CNT_W'(held_list.size());
		return r;
	endfunction

	function automatic stim_t random_command();
		stim_t s;
		int    k;
		int    j;
		s = '0;
		k = $urandom_range(99);
		if (k < 2)       s.cmd = CMD_CLEAR;
		else if (k < 40) s.cmd = CMD_INSERT;
		else if (k < 50) s.cmd = CMD_POP;
		else if (k < 60) s.cmd = CMD_POP_CLS;
		else if (k < 70) s.cmd = CMD_POP_NOT;
		else if (k < 80) s.cmd = CMD_REMOVE;
		else if (k < 90) s.cmd = CMD_QUERY;
		else             s.cmd = CMD_LOOKUP;
		s.item = 8'($urandom_range(255));
		s.cls = ($urandom_range(9) < 9) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
		case ($urandom_range(3))
			0: s.weight = $signed($urandom_range(8)) - 4;
			1: begin
				case ($urandom_range(3))
					0: s.weight = W_MAX;
					1: s.weight = W_MIN;
					2: s.weight = 32'sd0;
					default: s.weight = -32'sd1;
				endcase
			end
			default: s.weight = $urandom;
		endcase
		s.mask = 5'($urandom_range(31));
		// mostly name an entry that is held so removes and lookups hit
		if ((s.cmd == CMD_REMOVE || s.cmd == CMD_LOOKUP) && held_list.size() > 0
				&& $urandom_range(3) != 0) begin
			j = $urandom_range(held_list.size() - 1);
			s.item = held_list[j].item;
			s.cls = held_list[j].cls;
		end
		return s;
	endfunction

	task automatic issue(input stim_t s);
		result_t r;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= s.cmd;
		item_id <= s.item;
		item_class <= s.cls;
		weight <= s.weight;
		class_mask <= s.mask;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		r = list_apply(s);
		pending_results.push_back(s.has_exp ? s.exp : r);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				mismatches++;
			end else begin
				e = pending_results[0];
				pending_results.delete(0);
				check_field("status", 32'(e.status), 32'(status));
				check_field("out_item", 32'(e.item), 32'(out_item));
				check_field("out_class", 32'(e.cls), 32'(out_class));
				check_field("out_weight", e.weight, out_weight);
				check_field("entry_count", 32'(e.count), 32'(entry_count));
			end
		end
	end

	initial begin
		stim_t s;
		int    n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i])
			issue(DIRECTED[i]);
		drain();
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 6 : (phase == 1) ? 79 : 0;
			n = 0;
			while (n < 333) begin
				if ($urandom_range(99) < 3) begin
					// run of inserts to reach a full list
					repeat (18) begin
						s = random_command();
						s.cmd = CMD_INSERT;
						issue(s);
					end
					n += 18;
				end else begin
					issue(random_command());
					n++;
				end
			end
			drain();
			repeat (40) @(posedge clk);
		end
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ctspl_pkg.sv
rtl/ctspl_ram.sv
rtl/ctspl_match.sv
rtl/class_tagged_sorted_priority_list.sv
verif/tb.sv
